// ===== src/segment_intersection_test_unit_macros.svh =====
// Assertion macros for the segment intersection test unit.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_MACROS_SVH

// checked only outside reset
`define SIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sit_pkg.sv =====
// Shared types for the segment intersection test unit.
// No dependencies.
package sit_pkg;

    // sign of the orientation test, collinear cases folded in
    typedef enum logic [1:0] {
        ORI_NEG  = 2'b11,
        ORI_ZERO = 2'b00,
        ORI_POS  = 2'b01
    } orient_t;

    // per-pair flags marking which segment is a single point, used in the decision logic
    typedef struct packed {
        logic first_point;
        logic second_point;
    } degen_t;

endpackage

// ===== src/sit_seg_if.sv =====
// Valid/ready channel carrying one segment pair word.
// Depends on nothing; width set by parameter W.
interface sit_seg_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_start_x;
    logic signed [W-1:0] first_start_y;
    logic signed [W-1:0] first_end_x;
    logic signed [W-1:0] first_end_y;
    logic signed [W-1:0] second_start_x;
    logic signed [W-1:0] second_start_y;
    logic signed [W-1:0] second_end_x;
    logic signed [W-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

// ===== src/sit_hit_if.sv =====
// Valid/ready channel carrying one intersection result word.
// Depends on nothing.
interface sit_hit_if;
    logic valid;
    logic ready;
    logic segments_touch;

    modport source (output valid, segments_touch, input ready);
    modport sink (input valid, segments_touch, output ready);
endinterface

// ===== src/sit_orient.sv =====
// Orientation test of point c against directed line a->b, exact integer math.
// Depends on sit_pkg.
module sit_orient #(
    parameter int W = 16
) (
    input  logic signed [W-1:0] ax,
    input  logic signed [W-1:0] ay,
    input  logic signed [W-1:0] bx,
    input  logic signed [W-1:0] by,
    input  logic signed [W-1:0] cx,
    input  logic signed [W-1:0] cy,
    output sit_pkg::orient_t    ori
);
    import sit_pkg::*;

    logic signed [W:0]       ux, uy, wx, wy;
    logic        [W:0]       abs_ux, abs_uy, abs_wx, abs_wy;
    logic signed [2*W+1:0]   lhs, rhs;
    logic                    opposite, further;

    assign ux = {bx[W-1], bx} - {ax[W-1], ax};
    assign uy = {by[W-1], by} - {ay[W-1], ay};
    assign wx = {cx[W-1], cx} - {ax[W-1], ax};
    assign wy = {cy[W-1], cy} - {ay[W-1], ay};

    assign lhs = ux * wy;
    assign rhs = uy * wx;

    assign abs_ux = ux[W] ? -ux : ux;
    assign abs_uy = uy[W] ? -uy : uy;
    assign abs_wx = wx[W] ? -wx : wx;
    assign abs_wy = wy[W] ? -wy : wy;

    // componentwise opposite direction, i.e. a product of negative sign
    assign opposite = (ux[W] && wx > 0) || (ux > 0 && wx[W]) ||
                      (uy[W] && wy > 0) || (uy > 0 && wy[W]);

    // collinear, same direction: c = a + t*(b-a) with t >= 0, so |v2| > |v1|
    // shows in either component; also covers a zero-length v1
    assign further = (abs_wx > abs_ux) || (abs_wy > abs_uy);

    always_comb
    begin
        priority if (lhs > rhs)
            ori = ORI_POS;
        else if (lhs < rhs)
            ori = ORI_NEG;
        else if (opposite)
            ori = ORI_NEG;
        else if (further)
            ori = ORI_POS;
        else
            ori = ORI_ZERO;
    end

endmodule

// ===== src/sit_hit.sv =====
// Intersection decision for one segment pair: four orientation tests plus
// the point-segment special cases. Depends on sit_pkg and sit_orient.
module sit_hit #(
    parameter int W = 16
) (
    input  logic signed [W-1:0] p1x,
    input  logic signed [W-1:0] p1y,
    input  logic signed [W-1:0] p2x,
    input  logic signed [W-1:0] p2y,
    input  logic signed [W-1:0] p3x,
    input  logic signed [W-1:0] p3y,
    input  logic signed [W-1:0] p4x,
    input  logic signed [W-1:0] p4y,
    output logic                touch
);
    import sit_pkg::*;

    orient_t o123, o124, o341, o342;
    degen_t  dg;
    logic    straddle_a, straddle_b;

    sit_orient #(.W(W)) u_o123 (
        .ax(p1x), .ay(p1y), .bx(p2x), .by(p2y), .cx(p3x), .cy(p3y), .ori(o123)
    );
    sit_orient #(.W(W)) u_o124 (
        .ax(p1x), .ay(p1y), .bx(p2x), .by(p2y), .cx(p4x), .cy(p4y), .ori(o124)
    );
    sit_orient #(.W(W)) u_o341 (
        .ax(p3x), .ay(p3y), .bx(p4x), .by(p4y), .cx(p1x), .cy(p1y), .ori(o341)
    );
    sit_orient #(.W(W)) u_o342 (
        .ax(p3x), .ay(p3y), .bx(p4x), .by(p4y), .cx(p2x), .cy(p2y), .ori(o342)
    );

    assign dg.first_point  = (p1x == p2x) && (p1y == p2y);
    assign dg.second_point = (p3x == p4x) && (p3y == p4y);

    // product of two orientations is <= 0 unless both share a nonzero sign
    assign straddle_a = !((o123 == ORI_POS && o124 == ORI_POS) ||
                          (o123 == ORI_NEG && o124 == ORI_NEG));
    assign straddle_b = !((o341 == ORI_POS && o342 == ORI_POS) ||
                          (o341 == ORI_NEG && o342 == ORI_NEG));

    always_comb
    begin
        unique case ({dg.first_point, dg.second_point})
            2'b11:
                touch = (p1x == p3x) && (p1y == p3y);
            2'b10:
                touch = (o341 == ORI_ZERO);
            2'b01:
                touch = (o123 == ORI_ZERO);
            2'b00:
                touch = straddle_a && straddle_b;
        endcase
    end

endmodule

// ===== src/segment_intersection_test_unit.sv =====
// Pipeline: input register, four parallel orientation units (two (W+1)x(W+1)
// products each), result register; the result word is shown from the result register.
// Throughput: one segment pair per cycle, as long as hits.ready does not hold a
// finished result word in the result register.
// Ready passes back combinationally, so a full pipe drains and refills with no bubble.
// Reset: rst_n asynchronous, clears both valid flags; payload is not reset.
module segment_intersection_test_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    sit_seg_if.sink       segs,
    sit_hit_if.source     hits
);
    import sit_pkg::*;

    logic                         s1_valid_reg, s1_valid_next;
    logic                         hit_valid_reg, hit_valid_next;
    logic                         touch_reg;
    logic signed [COORD_BITS-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic signed [COORD_BITS-1:0] p3x_reg, p3y_reg, p4x_reg, p4y_reg;
    logic                         touch_next;
    logic                         seg_acc, out_free;

    assign out_free   = !hit_valid_reg || hits.ready;
    assign segs.ready = !s1_valid_reg || out_free;
    assign seg_acc    = segs.valid && segs.ready;

    assign s1_valid_next  = seg_acc || (s1_valid_reg && !out_free);
    assign hit_valid_next = (s1_valid_reg && out_free) || (hit_valid_reg && !hits.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            hit_valid_reg <= hit_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_acc)
        begin
            p1x_reg <= segs.first_start_x;
            p1y_reg <= segs.first_start_y;
            p2x_reg <= segs.first_end_x;
            p2y_reg <= segs.first_end_y;
            p3x_reg <= segs.second_start_x;
            p3y_reg <= segs.second_start_y;
            p4x_reg <= segs.second_end_x;
            p4y_reg <= segs.second_end_y;
        end
        if (s1_valid_reg && out_free)
            touch_reg <= touch_next;
    end

    sit_hit #(.W(COORD_BITS)) u_hit (
        .p1x(p1x_reg), .p1y(p1y_reg), .p2x(p2x_reg), .p2y(p2y_reg),
        .p3x(p3x_reg), .p3y(p3y_reg), .p4x(p4x_reg), .p4y(p4y_reg),
        .touch(touch_next)
    );

    assign hits.valid          = hit_valid_reg;
    assign hits.segments_touch = touch_reg;

endmodule

// ===== src/sit_checker.sv =====
// Port-level checks for segment_intersection_test_unit, attached by bind.
// Depends on segment_intersection_test_unit_macros.svh.
`include "segment_intersection_test_unit_macros.svh"

module sit_checker #(
    parameter int W = 16
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic [W-1:0] fsx,
    input logic [W-1:0] fsy,
    input logic [W-1:0] fex,
    input logic [W-1:0] fey,
    input logic [W-1:0] ssx,
    input logic [W-1:0] ssy,
    input logic [W-1:0] sex,
    input logic [W-1:0] sey,
    input logic         out_valid,
    input logic         out_ready,
    input logic         touch
);
    logic in_acc, same_pair;

    assign in_acc    = in_valid && in_ready;
    assign same_pair = (fsx == ssx) && (fsy == ssy) && (fex == sex) && (fey == sey);

    // at the edge after reset is seen, the result side is empty
    `SIT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")
    `SIT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
    `SIT_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
    `SIT_ASSERT(a_latency, in_acc ##1 out_ready |=> out_valid, "result word late")
    `SIT_ASSERT(a_same_touch, in_acc && same_pair ##1 out_ready |=> out_valid && touch,
        "identical segments reported apart")

endmodule

bind segment_intersection_test_unit sit_checker #(.W(COORD_BITS)) u_sit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (segs.valid),
    .in_ready  (segs.ready),
    .fsx       (segs.first_start_x),
    .fsy       (segs.first_start_y),
    .fex       (segs.first_end_x),
    .fey       (segs.first_end_y),
    .ssx       (segs.second_start_x),
    .ssy       (segs.second_start_y),
    .sex       (segs.second_end_x),
    .sey       (segs.second_end_y),
    .out_valid (hits.valid),
    .out_ready (hits.ready),
    .touch     (hits.segments_touch)
);
